// ----- src/esc_pkg.sv -----
// Shared types, constants and the month-start table for the seconds-to-calendar pipeline.
// No dependencies; imported by all esc_* modules and the top level.
package esc_pkg;

    localparam logic [31:0] DIV60_M    = 32'h8888_8889; // x/60 = (x*M) >> 37
    localparam logic [31:0] DIV3_M     = 32'hAAAA_AAAB; // x/3  = (x*M) >> 33
    localparam logic [21:0] DIV1461_M  = 22'd2939744;   // floor(2^32/1461), one fix-up
    localparam logic [29:0] DIV7_M     = 30'd613566757; // ceil(2^32/7), exact here
    localparam logic [10:0] DAYS_CYCLE = 11'd1461;
    localparam logic [15:0] DAYS_END   = 16'd36525;     // first day of 2100
    localparam logic [11:0] BASE_YEAR  = 12'd2000;

    typedef struct packed {
        logic [5:0]  sec;
        logic [5:0]  min;
        logic [20:0] hours;   // total hours since base
        logic [15:0] days;    // total days since base
    } t_hms_w;

    typedef struct packed {
        logic [5:0]  sec;
        logic [5:0]  min;
        logic [4:0]  hr;
        logic [2:0]  wday;
        logic [11:0] year;
        logic [8:0]  doy;     // day of year from 0
        logic        leap;
        logic        oor;
    } t_ymd_w;

    // Day of year on which month (index 0..11) starts.
    function automatic logic [8:0] month_start(input logic [3:0] idx, input logic leap);
        logic [8:0] s;
        case (idx)
            4'd0:    s = 9'd0;
            4'd1:    s = 9'd31;
            4'd2:    s = 9'd59;
            4'd3:    s = 9'd90;
            4'd4:    s = 9'd120;
            4'd5:    s = 9'd151;
            4'd6:    s = 9'd181;
            4'd7:    s = 9'd212;
            4'd8:    s = 9'd243;
            4'd9:    s = 9'd273;
            4'd10:   s = 9'd304;
            4'd11:   s = 9'd334;
            default: s = 9'd0;
        endcase
        if (leap && idx >= 4'd2) begin
            s = s + 9'd1;
        end
        return s;
    endfunction

endpackage

// ----- src/epoch_seconds_to_calendar.sv -----
// Seconds since 2000-01-01 00:00:00 to calendar fields: a seven-stage pipeline
// that takes one word per cycle while the output is not held by i_stall.
// Depends on esc_pkg, esc_hms, esc_ymd, esc_month.
//
// Each input word (a 32-bit count of seconds since 2000-01-01 00:00:00) yields
// exactly one output word with second, minute, hour, year, month, day of month
// and weekday (Sunday 1 .. Saturday 7). Every fourth year is taken as leap, which
// is the true calendar for 2000..2099; inputs from 2100-01-01 on raise
// o_out_of_range and the other fields keep following the four-year rule, up to
// year 2136. Throughput is one word per cycle while no output word is held
// under i_stall. Three reciprocal multiplies split seconds into minutes, hours
// and days, a fourth pair splits days into four-year cycles and weekday, one
// stage picks the year in the cycle, and the last stage finds the month and is
// the output register. The whole pipeline holds while an output word waits
// under i_stall, so o_stall is raised only then; no word is lost or repeated.
// The block has no configuration and no state beyond the pipeline.
module epoch_seconds_to_calendar (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [31:0] i_seconds_since_base,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [5:0]  o_second_of_minute,
    output logic [5:0]  o_minute_of_hour,
    output logic [4:0]  o_hour_of_day,
    output logic [11:0] o_calendar_year,
    output logic [3:0]  o_month_number,
    output logic [4:0]  o_day_of_month,
    output logic [2:0]  o_weekday,
    output logic        o_out_of_range
);
    import esc_pkg::*;

    logic   en;          // global advance for every stage
    logic   hms_valid;
    t_hms_w hms_data;
    logic   ymd_valid;
    t_ymd_w ymd_data;
    t_ymd_w out_data;

    // Advance unless a finished word sits at the output and is being held off.
    assign en      = !(o_valid && i_stall);
    assign o_stall = !en;

    // Stages 1-3: seconds -> sec, min, hours, days
    esc_hms u_hms (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (en),
        .i_valid   (i_valid),
        .i_seconds (i_seconds_since_base),
        .o_valid   (hms_valid),
        .o_data    (hms_data)
    );

    // Stages 4-6: hour, weekday, year, day of year
    esc_ymd u_ymd (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (hms_valid),
        .i_data  (hms_data),
        .o_valid (ymd_valid),
        .o_data  (ymd_data)
    );

    // Stage 7: month / day of month, output register
    esc_month u_month (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (ymd_valid),
        .i_data  (ymd_data),
        .o_valid (o_valid),
        .o_data  (out_data),
        .o_month (o_month_number),
        .o_mday  (o_day_of_month)
    );

    assign o_second_of_minute = out_data.sec;
    assign o_minute_of_hour   = out_data.min;
    assign o_hour_of_day      = out_data.hr;
    assign o_calendar_year    = out_data.year;
    assign o_weekday          = out_data.wday;
    assign o_out_of_range     = out_data.oor;

    a_month_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_month_number >= 4'd1 && o_month_number <= 4'd12))
        else $error("month out of range");

    a_fields_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_weekday != 3'd0 && o_hour_of_day < 5'd24 &&
                     o_minute_of_hour < 6'd60 && o_second_of_minute < 6'd60 &&
                     o_day_of_month != 5'd0))
        else $error("time or weekday field out of range");

    a_oor_year: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_out_of_range) |-> (o_calendar_year <= 12'd2099))
        else $error("year beyond 2099 without out_of_range");

    a_hold_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_calendar_year) &&
                                  $stable(o_day_of_month)))
        else $error("output word changed while held");
endmodule

// ----- src/esc_hms.sv -----
// Stages 1-3: splits seconds into second, minute, total hours and total days.
// Depends on esc_pkg.
module esc_hms (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  logic            i_valid,
    input  logic [31:0]     i_seconds,
    output logic            o_valid,
    output esc_pkg::t_hms_w o_data
);
    import esc_pkg::*;

    logic [2:0]  r_v;
    logic [31:0] r1_t;
    logic [63:0] r1_p;
    logic [5:0]  r2_sec;
    logic [26:0] r2_q1;
    logic [58:0] r2_p;
    logic [5:0]  r3_sec;
    logic [5:0]  r3_min;
    logic [20:0] r3_q2;
    logic [52:0] r3_p;

    logic [26:0] n_q1;
    logic [20:0] n_q2;

    assign n_q1 = r1_p[63:37];
    assign n_q2 = r2_p[57:37];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[1:0], i_valid};
        end
        if (i_en) begin
            r1_t   <= i_seconds;
            r1_p   <= {32'd0, i_seconds} * {32'd0, DIV60_M};
            // t - 60*q mod 64: 60*q = 64*q - 4*q
            r2_sec <= r1_t[5:0] + {n_q1[3:0], 2'b00};
            r2_q1  <= n_q1;
            r2_p   <= {32'd0, n_q1} * {27'd0, DIV60_M};
            r3_sec <= r2_sec;
            r3_min <= r2_q1[5:0] + {n_q2[3:0], 2'b00};
            r3_q2  <= n_q2;
            r3_p   <= {32'd0, n_q2} * {21'd0, DIV3_M};
        end
    end

    assign o_valid      = r_v[2];
    assign o_data.sec   = r3_sec;
    assign o_data.min   = r3_min;
    assign o_data.hours = r3_q2;
    assign o_data.days  = r3_p[51:36]; // hours / 24
endmodule

// ----- src/esc_ymd.sv -----
// Stages 4-6: hour, weekday, four-year cycle, year and day of year.
// Depends on esc_pkg.
module esc_ymd (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  logic            i_valid,
    input  esc_pkg::t_hms_w i_data,
    output logic            o_valid,
    output esc_pkg::t_ymd_w o_data
);
    import esc_pkg::*;

    logic [2:0]  r_v;
    // stage 4
    logic [5:0]  r4_sec, r4_min;
    logic [4:0]  r4_hr;
    logic [15:0] r4_days;
    logic [37:0] r4_pc;
    logic [46:0] r4_pw;
    // stage 5
    logic [5:0]  r5_sec, r5_min;
    logic [4:0]  r5_hr;
    logic [2:0]  r5_wday;
    logic [5:0]  r5_cyc;
    logic [10:0] r5_rem;
    logic        r5_oor;
    // stage 6
    t_ymd_w      r6;

    logic [4:0]  n_hr;
    logic [16:0] n_d6;
    logic [5:0]  n_qc;
    logic [15:0] n_rc;
    logic [16:0] n_wr;
    logic [5:0]  n_cyc;
    logic [10:0] n_rem;
    logic [1:0]  n_yoff;
    logic [8:0]  n_doy;

    assign n_hr = i_data.hours[4:0] - ({i_data.days[0], 4'd0} + {i_data.days[1:0], 3'd0});
    assign n_d6 = {1'b0, i_data.days} + 17'd6;

    always_comb begin
        n_qc = r4_pc[37:32];
        n_rc = r4_days - 16'(n_qc) * 16'(DAYS_CYCLE);
        if (n_rc >= 16'(DAYS_CYCLE)) begin
            n_cyc = n_qc + 6'd1;
            n_rem = 11'(n_rc - 16'(DAYS_CYCLE));
        end else begin
            n_cyc = n_qc;
            n_rem = n_rc[10:0];
        end
        n_wr = ({1'b0, r4_days} + 17'd6) - 17'(r4_pw[44:32]) * 17'd7;
    end

    always_comb begin
        if (r5_rem < 11'd366) begin
            n_yoff = 2'd0;
            n_doy  = r5_rem[8:0];
        end else if (r5_rem < 11'd731) begin
            n_yoff = 2'd1;
            n_doy  = 9'(r5_rem - 11'd366);
        end else if (r5_rem < 11'd1096) begin
            n_yoff = 2'd2;
            n_doy  = 9'(r5_rem - 11'd731);
        end else begin
            n_yoff = 2'd3;
            n_doy  = 9'(r5_rem - 11'd1096);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[1:0], i_valid};
        end
        if (i_en) begin
            r4_sec  <= i_data.sec;
            r4_min  <= i_data.min;
            r4_hr   <= n_hr;
            r4_days <= i_data.days;
            r4_pc   <= {22'd0, i_data.days} * {16'd0, DIV1461_M};
            r4_pw   <= {30'd0, n_d6} * {17'd0, DIV7_M};

            r5_sec  <= r4_sec;
            r5_min  <= r4_min;
            r5_hr   <= r4_hr;
            r5_wday <= n_wr[2:0] + 3'd1;
            r5_cyc  <= n_cyc;
            r5_rem  <= n_rem;
            r5_oor  <= (r4_days >= DAYS_END);

            r6.sec  <= r5_sec;
            r6.min  <= r5_min;
            r6.hr   <= r5_hr;
            r6.wday <= r5_wday;
            r6.year <= BASE_YEAR + {4'd0, r5_cyc, 2'b00} + {10'd0, n_yoff};
            r6.doy  <= n_doy;
            r6.leap <= (n_yoff == 2'd0);
            r6.oor  <= r5_oor;
        end
    end

    assign o_valid = r_v[2];
    assign o_data  = r6;
endmodule

// ----- src/esc_month.sv -----
// Stage 7 and output register: month and day of month from day of year.
// Depends on esc_pkg.
module esc_month (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  logic            i_valid,
    input  esc_pkg::t_ymd_w i_data,
    output logic            o_valid,
    output esc_pkg::t_ymd_w o_data,
    output logic [3:0]      o_month,
    output logic [4:0]      o_mday
);
    import esc_pkg::*;

    logic        r_v;
    t_ymd_w      r_d;
    logic [3:0]  r_month;
    logic [4:0]  r_mday;
    logic [3:0]  n_idx;
    logic [8:0]  n_off;

    // independent compares against each month start, last hit wins
    always_comb begin
        n_idx = 4'd0;
        for (int i = 1; i < 12; i++) begin
            if (i_data.doy >= month_start(4'(i), i_data.leap)) begin
                n_idx = 4'(i);
            end
        end
        n_off = i_data.doy - month_start(n_idx, i_data.leap);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (i_en) begin
            r_v <= i_valid;
        end
        if (i_en) begin
            r_d     <= i_data;
            r_month <= n_idx + 4'd1;
            r_mday  <= n_off[4:0] + 5'd1;
        end
    end

    assign o_valid = r_v;
    assign o_data  = r_d;
    assign o_month = r_month;
    assign o_mday  = r_mday;
endmodule
